FILE: rtl/sorted_array_search_defines.svh
// ----------------------------------------------------------------------------
// sorted_array_search_defines
// assertion macros used by the checker file of the sorted array search
// ----------------------------------------------------------------------------
`ifndef SORTED_ARRAY_SEARCH_DEFINES_SVH
`define SORTED_ARRAY_SEARCH_DEFINES_SVH

// same-cycle implication, quiet while reset is low
`define SAS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet while reset is low
`define SAS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also holds through reset
`define SAS_ASSERT_NEXT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/sas_pkg.sv
// ----------------------------------------------------------------------------
// sas_pkg
// commands, microcode word layout, control program and dispatch table of the
// sorted array search
// ----------------------------------------------------------------------------
package sas_pkg;

  // command codes of the input transaction
  localparam logic [1:0] CMD_LOAD   = 2'd0;
  localparam logic [1:0] CMD_LINEAR = 2'd1;
  localparam logic [1:0] CMD_BINARY = 2'd2;

  // program addresses
  typedef logic [4:0] step_t;

  localparam step_t ST_IDLE     = 5'd0;
  localparam step_t ST_LOAD     = 5'd1;
  localparam step_t ST_S_INIT   = 5'd2;
  localparam step_t ST_S_RDKEY  = 5'd3;
  localparam step_t ST_S_KEY    = 5'd4;
  localparam step_t ST_S_RDPREV = 5'd5;
  localparam step_t ST_S_CMP    = 5'd6;
  localparam step_t ST_S_SHIFT  = 5'd7;
  localparam step_t ST_S_PLACE  = 5'd8;
  localparam step_t ST_S_END    = 5'd9;
  localparam step_t ST_L_INIT   = 5'd10;
  localparam step_t ST_L_RD     = 5'd11;
  localparam step_t ST_L_CMP    = 5'd12;
  localparam step_t ST_L_STEP   = 5'd13;
  localparam step_t ST_MISS     = 5'd14;
  localparam step_t ST_B_INIT   = 5'd15;
  localparam step_t ST_B_MID    = 5'd16;
  localparam step_t ST_B_CMP    = 5'd17;
  localparam step_t ST_B_NARROW = 5'd18;
  localparam step_t ST_B_HIT    = 5'd19;
  localparam step_t ST_L_HIT    = 5'd20;
  localparam step_t ST_REPLY    = 5'd21;

  // branch conditions
  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_ACCEPT,
    C_LAST,
    C_CNT_LE1,
    C_GT,
    C_EQ,
    C_J_ONE,
    C_I_MORE,
    C_IN_RANGE,
    C_OUT_FREE
  } cond_t;

  // memory read address source
  typedef enum logic [1:0] {
    RD_I,
    RD_JM1,
    RD_MID
  } rd_sel_t;

  // datapath operation of one step
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SORT_INIT,
    OP_KEY,
    OP_SHIFT,
    OP_PLACE,
    OP_CLOSE,
    OP_LIN_INIT,
    OP_DEC_J,
    OP_BIN_INIT,
    OP_MID,
    OP_NARROW,
    OP_HIT_J,
    OP_HIT_MID,
    OP_MISS,
    OP_REPLY
  } dp_op_t;

  // one control word
  typedef struct packed {
    cond_t   cond;
    logic    inv;
    logic    hold;
    logic    disp;
    logic    take;
    rd_sel_t rd;
    dp_op_t  op;
    step_t   target;
  } ctrl_t;

  // status from the datapath to the sequencer
  typedef struct packed {
    logic  accept;
    logic  last;
    logic  cnt_le1;
    logic  gt;
    logic  eq;
    logic  j_one;
    logic  i_more;
    logic  in_range;
    logic  out_free;
    step_t disp_step;
  } flags_t;

  function automatic ctrl_t mk(cond_t cond, logic inv, logic hold, rd_sel_t rd,
                               dp_op_t op, step_t target);
    ctrl_t w;
    w.cond   = cond;
    w.inv    = inv;
    w.hold   = hold;
    w.disp   = 1'b0;
    w.take   = 1'b0;
    w.rd     = rd;
    w.op     = op;
    w.target = target;
    return w;
  endfunction

  // control program
  function automatic ctrl_t ucode_rom(step_t step);
    ctrl_t w;
    w = mk(C_ALWAYS, 1'b0, 1'b0, RD_I, OP_NONE, ST_IDLE);
    case (step)
      ST_IDLE: begin
        w = mk(C_ACCEPT, 1'b0, 1'b1, RD_I, OP_NONE, ST_IDLE);
        w.disp = 1'b1;
        w.take = 1'b1;
      end
      ST_LOAD:     w = mk(C_LAST,     1'b1, 1'b0, RD_I,   OP_LOAD,      ST_IDLE);
      ST_S_INIT:   w = mk(C_CNT_LE1,  1'b0, 1'b0, RD_I,   OP_SORT_INIT, ST_S_END);
      ST_S_RDKEY:  w = mk(C_NEVER,    1'b0, 1'b0, RD_I,   OP_NONE,      ST_IDLE);
      ST_S_KEY:    w = mk(C_NEVER,    1'b0, 1'b0, RD_I,   OP_KEY,       ST_IDLE);
      ST_S_RDPREV: w = mk(C_NEVER,    1'b0, 1'b0, RD_JM1, OP_NONE,      ST_IDLE);
      ST_S_CMP:    w = mk(C_GT,       1'b1, 1'b0, RD_JM1, OP_NONE,      ST_S_PLACE);
      ST_S_SHIFT:  w = mk(C_J_ONE,    1'b1, 1'b0, RD_JM1, OP_SHIFT,     ST_S_RDPREV);
      ST_S_PLACE:  w = mk(C_I_MORE,   1'b0, 1'b0, RD_I,   OP_PLACE,     ST_S_RDKEY);
      ST_S_END:    w = mk(C_ALWAYS,   1'b0, 1'b0, RD_I,   OP_CLOSE,     ST_IDLE);
      ST_L_INIT:   w = mk(C_NEVER,    1'b0, 1'b0, RD_JM1, OP_LIN_INIT,  ST_IDLE);
      ST_L_RD:     w = mk(C_NEVER,    1'b0, 1'b0, RD_JM1, OP_NONE,      ST_IDLE);
      ST_L_CMP:    w = mk(C_EQ,       1'b0, 1'b0, RD_JM1, OP_NONE,      ST_L_HIT);
      ST_L_STEP:   w = mk(C_J_ONE,    1'b1, 1'b0, RD_JM1, OP_DEC_J,     ST_L_RD);
      ST_MISS:     w = mk(C_ALWAYS,   1'b0, 1'b0, RD_I,   OP_MISS,      ST_REPLY);
      ST_B_INIT:   w = mk(C_NEVER,    1'b0, 1'b0, RD_MID, OP_BIN_INIT,  ST_IDLE);
      ST_B_MID:    w = mk(C_IN_RANGE, 1'b1, 1'b0, RD_MID, OP_MID,       ST_MISS);
      ST_B_CMP:    w = mk(C_EQ,       1'b0, 1'b0, RD_MID, OP_NONE,      ST_B_HIT);
      ST_B_NARROW: w = mk(C_ALWAYS,   1'b0, 1'b0, RD_MID, OP_NARROW,    ST_B_MID);
      ST_B_HIT:    w = mk(C_ALWAYS,   1'b0, 1'b0, RD_I,   OP_HIT_MID,   ST_REPLY);
      ST_L_HIT:    w = mk(C_NEVER,    1'b0, 1'b0, RD_I,   OP_HIT_J,     ST_IDLE);
      ST_REPLY:    w = mk(C_OUT_FREE, 1'b0, 1'b1, RD_I,   OP_REPLY,     ST_IDLE);
      default:     w = mk(C_ALWAYS,   1'b0, 1'b0, RD_I,   OP_NONE,      ST_IDLE);
    endcase
    return w;
  endfunction

  // entry point for an accepted command
  function automatic step_t dispatch(logic [1:0] cmd, logic query_ok);
    step_t s;
    case (cmd)
      CMD_LOAD:   s = ST_LOAD;
      CMD_LINEAR: s = query_ok ? ST_L_INIT : ST_MISS;
      CMD_BINARY: s = query_ok ? ST_B_INIT : ST_MISS;
      default:    s = ST_IDLE;
    endcase
    return s;
  endfunction

endpackage

FILE: rtl/sorted_array_search.sv
// ----------------------------------------------------------------------------
// sorted_array_search
// loads signed words, sorts them in place and answers linear and binary
// searches over the sorted store
// ----------------------------------------------------------------------------
// usage
//   in_*  : command transactions. in_tdata holds cmd (load, linear, binary)
//           and the value; in_tlast marks the final load and starts the sort.
//   out_* : one transaction per query, found flag and position.
//   the sort after the last load is an in-place insertion sort with a
//   quadratic worst case. a linear query scans words down from the top,
//   a binary query probes midpoints. both are paced by the single memory
//   port with a registered read in front of each compare, walked by the
//   microcode sequencer. a query on an open or empty set answers not found.
//   reset empties the set (marked closed) and clears the output; the store
//   needs no clearing. a stalled receiver holds the result in the output
//   register; the next query runs up to its reply and then holds the input
//   off until that result has left.
// ----------------------------------------------------------------------------
module sorted_array_search #(
  parameter int DEPTH      = 1024,
  parameter int DATA_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // cmd[1:0], value[33:2], zero[39:34]
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // found[0], position[10:1], zero[15:11]
);
  import sas_pkg::*;

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  ctrl_t  ctrl;
  flags_t flags;

  // input fields
  logic [1:0]            in_cmd;
  logic [31:0]           in_value;
  logic [63:0]           value_wide;
  logic [DATA_WIDTH-1:0] value_key;
  logic                  accept;

  // datapath registers
  logic [DATA_WIDTH-1:0] key_r, key_nxt;
  logic                  last_r, last_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic                  closed_r, closed_nxt;
  logic [CW-1:0]         i_r, i_nxt;
  logic [CW-1:0]         j_r, j_nxt;
  logic [CW-1:0]         low_r, low_nxt;
  logic [CW-1:0]         hp1_r, hp1_nxt;
  logic [IW-1:0]         mid_r, mid_nxt;
  logic                  res_found_r, res_found_nxt;
  logic [IW-1:0]         res_idx_r, res_idx_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_found_r, out_found_nxt;
  logic [9:0]            out_pos_r, out_pos_nxt;
  logic [DATA_WIDTH-1:0] rdata_r;

  // derived values
  logic [CW-1:0]         eff_cnt;
  logic                  load_room;
  logic [CW-1:0]         jm1;
  logic [CW:0]           mid_sum;
  logic [IW-1:0]         mid_calc;
  logic [31:0]           res_idx_wide;
  logic                  out_free;

  // memory ports
  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic                  wr_en;
  logic [IW-1:0]         wr_addr;
  logic [DATA_WIDTH-1:0] wr_data;
  logic [IW-1:0]         rd_addr;

  sas_useq u_useq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .ctrl  (ctrl)
  );

  // input unpacking, value sign-extended then cut to the word width
  assign in_cmd     = in_tdata[1:0];
  assign in_value   = in_tdata[33:2];
  assign value_wide = {{32{in_value[31]}}, in_value};
  assign value_key  = value_wide[DATA_WIDTH-1:0];
  assign in_tready  = ctrl.take;
  assign accept     = in_tvalid & in_tready;

  // address arithmetic
  assign eff_cnt   = closed_r ? '0 : cnt_r;
  assign load_room = eff_cnt < CW'(DEPTH);
  assign jm1       = j_r - CW'(1);
  assign mid_sum   = {1'b0, low_r} + {1'b0, hp1_r} - (CW + 1)'(1);
  assign mid_calc  = mid_sum[IW:1];
  assign out_free  = !out_valid_r || out_tready;

  // status for the sequencer
  always_comb begin
    flags.accept    = accept;
    flags.last      = last_r;
    flags.cnt_le1   = cnt_r <= CW'(1);
    flags.gt        = $signed(rdata_r) > $signed(key_r);
    flags.eq        = rdata_r == key_r;
    flags.j_one     = j_r == CW'(1);
    flags.i_more    = (i_r + CW'(1)) < cnt_r;
    flags.in_range  = low_r < hp1_r;
    flags.out_free  = out_free;
    flags.disp_step = dispatch(in_cmd, closed_r && (cnt_r != '0));
  end

  // memory port control
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = j_r[IW-1:0];
    wr_data = key_r;
    case (ctrl.op)
      OP_LOAD: begin
        wr_en   = load_room;
        wr_addr = eff_cnt[IW-1:0];
      end
      OP_SHIFT: begin
        wr_en   = 1'b1;
        wr_data = rdata_r;
      end
      OP_PLACE: begin
        wr_en   = 1'b1;
      end
      default: begin
        wr_en   = 1'b0;
      end
    endcase
    case (ctrl.rd)
      RD_I:    rd_addr = i_r[IW-1:0];
      RD_JM1:  rd_addr = jm1[IW-1:0];
      RD_MID:  rd_addr = mid_calc;
      default: rd_addr = i_r[IW-1:0];
    endcase
  end

  // word store, one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_r <= mem[rd_addr];
  end

  assign res_idx_wide = 32'(res_idx_r);

  // datapath next values
  always_comb begin
    key_nxt       = key_r;
    last_nxt      = last_r;
    cnt_nxt       = cnt_r;
    closed_nxt    = closed_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    low_nxt       = low_r;
    hp1_nxt       = hp1_r;
    mid_nxt       = mid_r;
    res_found_nxt = res_found_r;
    res_idx_nxt   = res_idx_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_found_nxt = out_found_r;
    out_pos_nxt   = out_pos_r;
    if (accept) begin
      key_nxt  = value_key;
      last_nxt = in_tlast;
    end
    case (ctrl.op)
      OP_LOAD: begin
        closed_nxt = 1'b0;
        cnt_nxt    = load_room ? eff_cnt + CW'(1) : eff_cnt;
      end
      OP_SORT_INIT: i_nxt = CW'(1);
      OP_KEY: begin
        key_nxt = rdata_r;
        j_nxt   = i_r;
      end
      OP_SHIFT:    j_nxt = jm1;
      OP_PLACE:    i_nxt = i_r + CW'(1);
      OP_CLOSE:    closed_nxt = 1'b1;
      OP_LIN_INIT: j_nxt = cnt_r;
      OP_DEC_J:    j_nxt = jm1;
      OP_BIN_INIT: begin
        low_nxt = '0;
        hp1_nxt = cnt_r;
      end
      OP_MID:      mid_nxt = mid_calc;
      OP_NARROW: begin
        if (flags.gt) begin
          hp1_nxt = CW'(mid_r);
        end else begin
          low_nxt = CW'(mid_r) + CW'(1);
        end
      end
      OP_HIT_J: begin
        res_found_nxt = 1'b1;
        res_idx_nxt   = jm1[IW-1:0];
      end
      OP_HIT_MID: begin
        res_found_nxt = 1'b1;
        res_idx_nxt   = mid_r;
      end
      OP_MISS: begin
        res_found_nxt = 1'b0;
        res_idx_nxt   = '0;
      end
      OP_REPLY: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = res_found_r;
          out_pos_nxt   = res_idx_wide[9:0];
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      closed_r    <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      closed_r    <= closed_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    key_r       <= key_nxt;
    last_r      <= last_nxt;
    i_r         <= i_nxt;
    j_r         <= j_nxt;
    low_r       <= low_nxt;
    hp1_r       <= hp1_nxt;
    mid_r       <= mid_nxt;
    res_found_r <= res_found_nxt;
    res_idx_r   <= res_idx_nxt;
    out_found_r <= out_found_nxt;
    out_pos_r   <= out_pos_nxt;
  end

  // result channel
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_pos_r, out_found_r};

endmodule

FILE: rtl/sas_useq.sv
// ----------------------------------------------------------------------------
// sas_useq
// step counter and control store of the sorted array search sequencer
// ----------------------------------------------------------------------------
module sas_useq (
  input  logic            clk,
  input  logic            rst_n,
  input  sas_pkg::flags_t flags,
  output sas_pkg::ctrl_t  ctrl
);
  import sas_pkg::*;

  step_t step_r;
  step_t step_nxt;
  logic  cond_hit;
  logic  jump;

  // control word of the current step
  assign ctrl = ucode_rom(step_r);

  // condition select and next step
  always_comb begin
    case (ctrl.cond)
      C_NEVER:    cond_hit = 1'b0;
      C_ALWAYS:   cond_hit = 1'b1;
      C_ACCEPT:   cond_hit = flags.accept;
      C_LAST:     cond_hit = flags.last;
      C_CNT_LE1:  cond_hit = flags.cnt_le1;
      C_GT:       cond_hit = flags.gt;
      C_EQ:       cond_hit = flags.eq;
      C_J_ONE:    cond_hit = flags.j_one;
      C_I_MORE:   cond_hit = flags.i_more;
      C_IN_RANGE: cond_hit = flags.in_range;
      C_OUT_FREE: cond_hit = flags.out_free;
      default:    cond_hit = 1'b0;
    endcase
    jump = cond_hit ^ ctrl.inv;
    if (jump) begin
      step_nxt = ctrl.disp ? flags.disp_step : ctrl.target;
    end else if (ctrl.hold) begin
      step_nxt = step_r;
    end else begin
      step_nxt = step_r + step_t'(1);
    end
  end

  // step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= ST_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

FILE: rtl/sas_check.sv
// ----------------------------------------------------------------------------
// sas_check
// port-level checks of the sorted array search, bound to the top level
// ----------------------------------------------------------------------------
`include "sorted_array_search_defines.svh"

module sas_check (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [39:0] in_tdata,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);

  // a stalled result stays offered
  `SAS_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid, "result dropped while stalled")

  // a stalled result keeps its payload
  `SAS_ASSERT_NEXT(a_out_stable, out_tvalid && !out_tready, $stable(out_tdata), "result changed while stalled")

  // reset leaves no result pending
  `SAS_ASSERT_NEXT_ALWAYS(a_reset_empty, !rst_n, !out_tvalid, "result pending after reset")

  // a miss reports position zero
  `SAS_ASSERT_SAME(a_miss_pos, out_tvalid && !out_tdata[0], out_tdata[10:1] == 10'd0, "miss with nonzero position")

  // a load or query transaction occupies the sequencer for the next cycle
  `SAS_ASSERT_NEXT(a_busy_after_cmd, in_tvalid && in_tready && (in_tdata[1:0] != 2'd3), !in_tready, "ready right after a command")

endmodule

bind sorted_array_search sas_check u_sas_check (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

FILE: dv/tb_sorted_array_search.sv
// ----------------------------------------------------------------------------
// tb_sorted_array_search
// self-checking bench for the sorted array search: command transactions are
// driven on the input stream, a behavioral copy of the store predicts every
// query answer, and each answer on the result stream is compared in order
// ----------------------------------------------------------------------------
module tb_sorted_array_search;
  timeunit 1ns;
  timeprecision 1ps;

  import sas_pkg::*;

  localparam int DEPTH = 1024;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] WORD_MAX = 32'sh7fff_ffff;
  localparam int RANDOM_ITEMS = 520;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 64;
  localparam int QUIET_LIMIT = 40000;
  localparam int MAX_PRINTED = 40;

  typedef struct packed {
    logic       found;
    logic [9:0] position;
  } answer_t;

  // behavioral copy of the store and the queue of answers still owed
  class search_checker;
    logic signed [31:0] store [DEPTH];
    int                 count;
    bit                 closed;
    answer_t            answers_due [$];
    int                 errors;
    int                 loads;
    int                 linear_q;
    int                 binary_q;
    int                 hits;
    int                 sets;
    int                 checked;

    function new();
      count    = 0;
      closed   = 1'b1;
      errors   = 0;
      loads    = 0;
      linear_q = 0;
      binary_q = 0;
      hits     = 0;
      sets     = 0;
      checked  = 0;
    endfunction

    // ascending insertion sort over the loaded words
    function void sort_set();
      int                 j;
      logic signed [31:0] key;
      for (int i = 1; i < count; i++) begin
        key = store[i];
        j = i;
        while (j > 0 && store[j-1] > key) begin
          store[j] = store[j-1];
          j--;
        end
        store[j] = key;
      end
    endfunction

    // scan down from the top, highest matching index wins
    function bit find_linear(logic signed [31:0] target, output int idx);
      idx = 0;
      for (int n = count; n > 0; n--) begin
        if (store[n-1] == target) begin
          idx = n - 1;
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    // floor midpoint probes, first hit wins
    function bit find_binary(logic signed [31:0] target, output int idx);
      int lo;
      int hi;
      int mid;
      lo  = 0;
      hi  = count - 1;
      idx = 0;
      while (lo <= hi) begin
        mid = (lo + hi) / 2;
        if (store[mid] == target) begin
          idx = mid;
          return 1'b1;
        end
        if (store[mid] > target) hi = mid - 1;
        else lo = mid + 1;
      end
      return 1'b0;
    endfunction

    function void note_input(logic [1:0] cmd, logic signed [31:0] value, logic last);
      bit      hit;
      int      idx;
      answer_t a;
      hit = 1'b0;
      idx = 0;
      case (cmd)
        CMD_LOAD: begin
          loads++;
          // a load into a closed set starts a new one
          if (closed) begin
            count  = 0;
            closed = 1'b0;
          end
          // words past the depth are dropped
          if (count < DEPTH) begin
            store[count] = value;
            count++;
          end
          if (last) begin
            sort_set();
            closed = 1'b1;
            sets++;
          end
        end
        CMD_LINEAR, CMD_BINARY: begin
          if (cmd == CMD_LINEAR) linear_q++;
          else binary_q++;
          // open or empty set answers not found
          if (closed && count > 0) begin
            if (cmd == CMD_LINEAR) hit = find_linear(value, idx);
            else hit = find_binary(value, idx);
          end
          if (!hit) idx = 0;
          if (hit) hits++;
          a.found    = hit;
          a.position = idx[9:0];
          answers_due.push_back(a);
        end
        default: ;
      endcase
    endfunction

    task report_mismatch(string msg);
      errors++;
      if (errors <= MAX_PRINTED) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_result(logic found, logic [9:0] position);
      answer_t want;
      checked++;
      if (answers_due.size() == 0) begin
        report_mismatch($sformatf("answer found=%0b position=%0d with no query waiting",
                                  found, position));
        return;
      end
      want = answers_due.pop_front();
      if (found !== want.found)
        report_mismatch($sformatf("found %0b, expected %0b", found, want.found));
      if (position !== want.position)
        report_mismatch($sformatf("position %0d, expected %0d", position, want.position));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;   // cmd[1:0], value[33:2], zero[39:34]
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // found[0], position[10:1], zero[15:11]

  search_checker      checker_h = new();
  int                 idle_pct = 0;
  int                 stall_pct = 0;
  bit                 hold_req = 1'b0;
  bit                 hold_before_queries = 1'b0;
  int                 sent = 0;
  int                 quiet_cycles = 0;
  logic signed [31:0] set_words [$];

  sorted_array_search dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // observe both streams at the edge that completes a transaction
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready)
      checker_h.note_input(in_tdata[1:0], in_tdata[33:2], in_tlast);
    if (rst_n && out_tvalid && out_tready)
      checker_h.check_result(out_tdata[0], out_tdata[10:1]);
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result receiver: random stalls, plus one long hold-off on request
  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
    end
  end

  // offer one command, with an optional idle gap, until it is taken
  task automatic send_item(logic [1:0] cmd, logic signed [31:0] value, logic last);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'b0, value, cmd};
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    if (cmd != CMD_UNUSED) sent++;
  endtask

  function automatic logic [1:0] pick_query();
    return ($urandom_range(1) == 0) ? CMD_LINEAR : CMD_BINARY;
  endfunction

  // narrow words crowd into a few values so duplicates are common
  function automatic logic signed [31:0] pick_word(bit narrow);
    int r;
    r = $urandom_range(19);
    if (narrow || r < 2) return $urandom_range(15) - 8;
    if (r == 2) return WORD_MIN;
    if (r == 3) return WORD_MAX;
    return $urandom;
  endfunction

  // when the set has words, half the keys hit it, some land just beside a stored word
  function automatic logic signed [31:0] pick_key(bit narrow);
    int                 r;
    logic signed [31:0] w;
    r = $urandom_range(99);
    if (set_words.size() == 0 || r >= 65) return pick_word(narrow);
    w = set_words[$urandom_range(set_words.size() - 1)];
    if (r < 50) return w;
    return (r < 58) ? w + 1 : w - 1;
  endfunction

  // one set: loads, usually closed by a last mark, then a burst of queries
  task automatic run_random_set(bit narrow);
    int                 size;
    int                 queries;
    bit                 closes;
    logic signed [31:0] w;
    size    = ($urandom_range(9) == 0) ? $urandom_range(13, 48) : $urandom_range(1, 12);
    closes  = ($urandom_range(7) != 0);
    queries = $urandom_range(2, 10);
    set_words.delete();
    for (int i = 0; i < size; i++) begin
      // now and then a stray query or unused command lands mid-set
      if ($urandom_range(19) == 0)
        send_item(($urandom_range(2) == 0) ? CMD_UNUSED : pick_query(),
                  pick_key(narrow), 1'($urandom_range(1)));
      w = pick_word(narrow);
      set_words.push_back(w);
      send_item(CMD_LOAD, w, closes && (i == size - 1));
    end
    if (hold_before_queries) begin
      hold_before_queries = 1'b0;
      hold_req = 1'b1;
    end
    for (int q = 0; q < queries; q++) begin
      if ($urandom_range(15) == 0) send_item(CMD_UNUSED, $urandom, 1'($urandom_range(1)));
      send_item(pick_query(), pick_key(narrow), 1'($urandom_range(1)));
    end
  endtask

  initial begin
    int                 goal;
    logic signed [31:0] w;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tlast  <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty set, unused command, open-set queries, duplicates
    send_item(CMD_LINEAR, 32'sd0, 1'b0);
    send_item(CMD_BINARY, WORD_MIN, 1'b1);
    send_item(CMD_UNUSED, WORD_MAX, 1'b0);
    send_item(CMD_LOAD, WORD_MAX, 1'b0);
    send_item(CMD_LOAD, WORD_MIN, 1'b0);
    send_item(CMD_LINEAR, 32'sd5, 1'b0);
    send_item(CMD_LOAD, 32'sd5, 1'b0);
    send_item(CMD_LOAD, -32'sd1, 1'b0);
    send_item(CMD_LOAD, 32'sd5, 1'b0);
    send_item(CMD_BINARY, 32'sd5, 1'b0);
    send_item(CMD_LOAD, 32'sd5, 1'b1);
    send_item(CMD_LINEAR, 32'sd5, 1'b0);
    send_item(CMD_BINARY, 32'sd5, 1'b0);
    send_item(CMD_LINEAR, WORD_MIN, 1'b1);
    send_item(CMD_BINARY, WORD_MAX, 1'b0);
    send_item(CMD_BINARY, WORD_MIN, 1'b0);
    send_item(CMD_LINEAR, WORD_MAX, 1'b0);
    send_item(CMD_BINARY, 32'sd4, 1'b0);
    send_item(CMD_LINEAR, 32'sd6, 1'b0);
    send_item(CMD_UNUSED, 32'sd0, 1'b1);
    send_item(CMD_LOAD, 32'sd3, 1'b1);
    send_item(CMD_BINARY, 32'sd3, 1'b0);
    send_item(CMD_LINEAR, 32'sd2, 1'b0);

    // full store plus two dropped words, the last mark on a dropped one
    for (int i = 0; i < DEPTH + 2; i++) begin
      if (i < DEPTH) w = -32'sd300000 + i * 587;
      else w = WORD_MIN + i;
      send_item(CMD_LOAD, w, i == DEPTH + 1);
    end
    send_item(CMD_LINEAR, -32'sd300000 + 1023 * 587, 1'b0);
    send_item(CMD_BINARY, -32'sd300000, 1'b0);
    send_item(CMD_BINARY, -32'sd300000 + 511 * 587, 1'b0);
    send_item(CMD_BINARY, -32'sd300000 + 700 * 587, 1'b0);
    send_item(CMD_LINEAR, -32'sd300000, 1'b0);
    send_item(CMD_LINEAR, WORD_MIN + DEPTH, 1'b0);
    send_item(CMD_BINARY, WORD_MIN + DEPTH + 1, 1'b0);

    // random sets under four flow-control mixes
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
          hold_before_queries = 1'b1;
        end
        1: begin
          idle_pct  = 69;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 69;
        end
        default: begin
          idle_pct  = 13;
          stall_pct = 13;
        end
      endcase
      goal = sent + RANDOM_ITEMS / 4;
      while (sent < goal) run_random_set($urandom_range(3) == 0);
    end

    // drain
    in_tvalid <= 1'b0;
    while (checker_h.answers_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("coverage: %0d loads in %0d closed sets, %0d linear and %0d binary queries",
             checker_h.loads, checker_h.sets, checker_h.linear_q, checker_h.binary_q);
    $display("coverage: %0d answers checked, %0d hits, %0d mismatches",
             checker_h.checked, checker_h.hits, checker_h.errors);
    if (checker_h.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
